// ===== src/rvg_pkg.sv =====
// ----------------------------------------------------------------------------
// rvg_pkg: shared types and constants of the radial gain pipeline
// Stage numbering, fixed-point widths, configuration codes and a rounding
// helper used by the gain polynomial module.
// ----------------------------------------------------------------------------
package rvg_pkg;

  // Field widths
  localparam int CENTRE_W   = 12;
  localparam int RECIP_W    = 32;
  localparam int COEF_W     = 16;
  localparam int R_W        = 20;   // unsigned Q4.16 powers of the radius
  localparam int GAIN_W     = 16;   // signed Q4.12 gain
  localparam int CH_W       = 8;
  localparam int FIELD_CH   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [R_W-1:0] R_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R4  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R6  = 3'd5;

  // Pipeline stages, in order
  localparam int ST_DIFF = 0;
  localparam int ST_SQ   = 1;
  localparam int ST_PP   = 2;
  localparam int ST_R2   = 3;
  localparam int ST_R2SQ = 4;
  localparam int ST_R4   = 5;
  localparam int ST_R6P  = 6;
  localparam int ST_R6   = 7;
  localparam int ST_TERM = 8;
  localparam int ST_GAIN = 9;
  localparam int ST_MUL  = 10;
  localparam int ST_OUT  = 11;
  localparam int NSTAGE  = 12;

  typedef logic [NSTAGE-1:0] stage_vec_t;
  typedef logic [CH_W-1:0]   pix_t;
  typedef pix_t [FIELD_CH-1:0] chans_t;

  typedef struct packed {
    logic [CENTRE_W-1:0]      centre_x;
    logic [CENTRE_W-1:0]      centre_y;
    logic [RECIP_W-1:0]       recip;
    logic signed [COEF_W-1:0] coef_r2;
    logic signed [COEF_W-1:0] coef_r4;
    logic signed [COEF_W-1:0] coef_r6;
  } cfg_t;

  // Round a Q8.32 product back to Q4.16 and saturate
  function automatic logic [R_W-1:0] round_sat(input logic [2*R_W-1:0] p);
    logic [2*R_W:0]    t;
    logic [R_W+4:0]    q;
    t = {1'b0, p} + (2*R_W+1)'(1 << 15);
    q = t[2*R_W:16];
    return (q > (R_W+5)'(R_MAX)) ? R_MAX : q[R_W-1:0];
  endfunction

endpackage

// ===== src/rvg_pipe.sv =====
// ----------------------------------------------------------------------------
// rvg_pipe: valid bits and stage enables of the gain pipeline
// A stage loads when it is empty or when the stage after it moves on,
// so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
module rvg_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output rvg_pkg::stage_vec_t en
);
  import rvg_pkg::*;

  stage_vec_t v;

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NSTAGE-1];

  // Reset empties every stage
  a_reset_empty: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("pipeline not empty after reset");

  // An accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted beat lost at pipeline entry");

  // A held stage keeps its item
  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((($past(v) & ~$past(en)) & ~v) == '0))
    else $error("held stage dropped its item");

  // A full pipeline behind a stalled output refuses input
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    ((&v) && out_stall) |-> in_stall)
    else $error("input taken while pipeline full and output stalled");

endmodule

// ===== src/rvg_radius.sv =====
// ----------------------------------------------------------------------------
// rvg_radius: squared distance to the optical centre, normalised to Q4.16
// Four stages: offsets, squares, split reciprocal products, round/saturate.
// ----------------------------------------------------------------------------
module rvg_radius #(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  rvg_pkg::stage_vec_t        en,
  input  rvg_pkg::cfg_t              cfg,
  input  logic [COORD_BITS-1:0]      pixel_row,
  input  logic [COORD_BITS-1:0]      pixel_col,
  output logic [rvg_pkg::R_W-1:0]    r2
);
  import rvg_pkg::*;

  localparam int DW  = COORD_BITS;
  localparam int SQW = 2 * DW;
  localparam int SW  = SQW + 1;
  localparam int HW  = RECIP_W / 2;
  localparam int PW  = (SW + RECIP_W + 1 > 53) ? SW + RECIP_W + 1 : 53;

  logic signed [DW:0]     dy, dx;
  logic signed [2*DW+1:0] sqy_full, sqx_full;
  logic [SQW-1:0]         sqy, sqx;
  logic [SW-1:0]          s;
  logic [SW+HW-1:0]       pp_lo_next, pp_hi_next, pp_lo, pp_hi;
  logic [PW-1:0]          full;
  logic [PW-33:0]         r2_pre;

  // Offsets: centre is taken modulo the coordinate range
  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      dy <= $signed({1'b0, DW'(cfg.centre_y)}) - $signed({1'b0, pixel_row});
      dx <= $signed({1'b0, DW'(cfg.centre_x)}) - $signed({1'b0, pixel_col});
    end
  end

  assign sqy_full = dy * dy;
  assign sqx_full = dx * dx;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      sqy <= sqy_full[SQW-1:0];
      sqx <= sqx_full[SQW-1:0];
    end
  end

  // Split the reciprocal into halves to keep each multiplier narrow
  assign s          = SW'(sqy) + SW'(sqx);
  assign pp_lo_next = (SW+HW)'(s) * (SW+HW)'(cfg.recip[HW-1:0]);
  assign pp_hi_next = (SW+HW)'(s) * (SW+HW)'(cfg.recip[RECIP_W-1:HW]);

  always_ff @(posedge clk) begin
    if (en[ST_PP]) begin
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
    end
  end

  assign full   = (PW'(pp_hi) << HW) + PW'(pp_lo) + (PW'(1) << 31);
  assign r2_pre = full[PW-1:32];

  always_ff @(posedge clk) begin
    if (en[ST_R2]) begin
      r2 <= (r2_pre > (PW-32)'(R_MAX)) ? R_MAX : r2_pre[R_W-1:0];
    end
  end

endmodule

// ===== src/rvg_poly.sv =====
// ----------------------------------------------------------------------------
// rvg_poly: gain polynomial 1 + a*r2 + b*r4 + c*r6 in signed Q4.12
// Higher powers alternate a multiply stage with a round/saturate stage.
// ----------------------------------------------------------------------------
module rvg_poly (
  input  logic                             clk,
  input  rvg_pkg::stage_vec_t              en,
  input  rvg_pkg::cfg_t                    cfg,
  input  logic [rvg_pkg::R_W-1:0]          r2_in,
  output logic signed [rvg_pkg::GAIN_W-1:0] gain
);
  import rvg_pkg::*;

  localparam int PRW = 2 * R_W;
  localparam int TW  = COEF_W + R_W + 1;
  localparam int AW  = TW + 2;
  localparam logic signed [AW-1:0] G_HI = AW'(32767);
  localparam logic signed [AW-1:0] G_LO = AW'(-32768);

  logic [PRW-1:0]        r2sq, r6p;
  logic [R_W-1:0]        r2_d4, r2_d5, r2_d6, r2_d7;
  logic [R_W-1:0]        r4, r4_d6, r4_d7, r6;
  logic signed [TW-1:0]  t2_next, t4_next, t6_next, t2, t4, t6;
  logic signed [AW-1:0]  acc, rnd, gp;

  always_ff @(posedge clk) begin
    if (en[ST_R2SQ]) begin
      r2sq  <= PRW'(r2_in) * PRW'(r2_in);
      r2_d4 <= r2_in;
    end
    if (en[ST_R4]) begin
      r4    <= round_sat(r2sq);
      r2_d5 <= r2_d4;
    end
    if (en[ST_R6P]) begin
      r6p   <= PRW'(r4) * PRW'(r2_d5);
      r2_d6 <= r2_d5;
      r4_d6 <= r4;
    end
    if (en[ST_R6]) begin
      r6    <= round_sat(r6p);
      r2_d7 <= r2_d6;
      r4_d7 <= r4_d6;
    end
  end

  assign t2_next = TW'(cfg.coef_r2) * TW'($signed({1'b0, r2_d7}));
  assign t4_next = TW'(cfg.coef_r4) * TW'($signed({1'b0, r4_d7}));
  assign t6_next = TW'(cfg.coef_r6) * TW'($signed({1'b0, r6}));

  always_ff @(posedge clk) begin
    if (en[ST_TERM]) begin
      t2 <= t2_next;
      t4 <= t4_next;
      t6 <= t6_next;
    end
  end

  // Round to Q.12 with floor semantics, add unity, saturate
  assign acc = AW'(t2) + AW'(t4) + AW'(t6);
  assign rnd = acc + AW'(32768);
  assign gp  = (rnd >>> 16) + AW'(4096);

  always_ff @(posedge clk) begin
    if (en[ST_GAIN]) begin
      if (gp > G_HI) begin
        gain <= G_HI[GAIN_W-1:0];
      end else if (gp < G_LO) begin
        gain <= G_LO[GAIN_W-1:0];
      end else begin
        gain <= gp[GAIN_W-1:0];
      end
    end
  end

endmodule

// ===== src/rvg_scale.sv =====
// ----------------------------------------------------------------------------
// rvg_scale: channel delay line and per-channel gain multiply with clamp
// Channels ride alongside the gain stages, then are scaled and clamped.
// ----------------------------------------------------------------------------
module rvg_scale #(
  parameter int CHANNELS = 3
) (
  input  logic                              clk,
  input  rvg_pkg::stage_vec_t               en,
  input  rvg_pkg::chans_t                   chan_in,
  input  logic signed [rvg_pkg::GAIN_W-1:0] gain,
  output rvg_pkg::chans_t                   chan_out
);
  import rvg_pkg::*;

  localparam int USED = (CHANNELS < FIELD_CH) ? CHANNELS : FIELD_CH;
  localparam int PRW  = CH_W + GAIN_W - 1;

  chans_t chd [ST_GAIN+1];
  logic   gpos;

  // Delay line: one slot per stage up to the gain stage
  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      chd[0] <= chan_in;
    end
    for (int k = 1; k <= ST_GAIN; k++) begin
      if (en[k]) begin
        chd[k] <= chd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      gpos <= !gain[GAIN_W-1] && (gain != '0);
    end
  end

  for (genvar i = 0; i < FIELD_CH; i++) begin : g_lane
    if (i < USED) begin : g_used
      logic [PRW-1:0] prod;
      logic [PRW:0]   rnd;
      logic [PRW-12:0] q;
      pix_t           res;

      always_ff @(posedge clk) begin
        if (en[ST_MUL]) begin
          prod <= PRW'(chd[ST_GAIN][i]) * PRW'(gain[GAIN_W-2:0]);
        end
      end

      assign rnd = {1'b0, prod} + (PRW+1)'(2048);
      assign q   = rnd[PRW:12];

      always_ff @(posedge clk) begin
        if (en[ST_OUT]) begin
          res <= !gpos ? '0 : (q > (PRW-11)'(255)) ? '1 : q[CH_W-1:0];
        end
      end

      assign chan_out[i] = res;
    end else begin : g_unused
      assign chan_out[i] = '0;
    end
  end

endmodule

// ===== src/radial_vignetting_gain_top.sv =====
// ----------------------------------------------------------------------------
// radial_vignetting_gain_top: radial polynomial lens-shading gain
// Scales each colour channel of a pixel by 1 + a*r2 + b*r4 + c*r6, where r2
// is the normalised squared distance from a programmable optical centre.
//
//   Channel | Signals                                   | Beat when
//   --------+-------------------------------------------+----------------------
//   in      | in_valid, in_stall, pixel_row/col, chanN_in | in_valid && !in_stall
//   out     | out_valid, out_stall, chanN_out           | out_valid && !out_stall
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// Throughput is one pixel per clock while out_stall is low; the valid-bit
// pipeline stages are offsets, squares, reciprocal products, r2, r2*r2, r4,
// r4*r2, r6, coefficient terms, gain, channel products and clamp.
// Reset clears the stage valid bits and the configuration registers; there
// is no clearing pass. Each stage holds while the stage after it is full and
// held, so a stalled output backs up one stage at a time and empty slots are
// filled from upstream; nothing is dropped or repeated.
// Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module radial_vignetting_gain_top #(
  parameter int CHANNELS   = 3,
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [COORD_BITS-1:0]            pixel_row,
  input  logic [COORD_BITS-1:0]            pixel_col,
  input  logic [rvg_pkg::CH_W-1:0]         chan0_in,
  input  logic [rvg_pkg::CH_W-1:0]         chan1_in,
  input  logic [rvg_pkg::CH_W-1:0]         chan2_in,
  // corrected pixel output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rvg_pkg::CH_W-1:0]         chan0_out,
  output logic [rvg_pkg::CH_W-1:0]         chan1_out,
  output logic [rvg_pkg::CH_W-1:0]         chan2_out,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rvg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rvg_pkg::*;

  cfg_t                     cfg;
  stage_vec_t               en;
  logic [R_W-1:0]           r2;
  logic signed [GAIN_W-1:0] gain;
  chans_t                   chan_in, chan_out;

  // Register file: always ready, writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTRE_X: cfg.centre_x <= cfg_data[CENTRE_W-1:0];
        REG_CENTRE_Y: cfg.centre_y <= cfg_data[CENTRE_W-1:0];
        REG_RECIP:    cfg.recip    <= cfg_data[RECIP_W-1:0];
        REG_COEF_R2:  cfg.coef_r2  <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_R4:  cfg.coef_r4  <= $signed(cfg_data[COEF_W-1:0]);
        REG_COEF_R6:  cfg.coef_r6  <= $signed(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stage control: valid bits and per-stage advance
  rvg_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  // Normalised squared radius, stages 0 to 3
  rvg_radius #(
    .COORD_BITS (COORD_BITS)
  ) u_radius (
    .clk       (clk),
    .en        (en),
    .cfg       (cfg),
    .pixel_row (pixel_row),
    .pixel_col (pixel_col),
    .r2        (r2)
  );

  // Gain polynomial, stages 4 to 9
  rvg_poly u_poly (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .r2_in (r2),
    .gain  (gain)
  );

  assign chan_in[0] = chan0_in;
  assign chan_in[1] = chan1_in;
  assign chan_in[2] = chan2_in;

  // Channel scaling, stages 10 and 11
  rvg_scale #(
    .CHANNELS (CHANNELS)
  ) u_scale (
    .clk      (clk),
    .en       (en),
    .chan_in  (chan_in),
    .gain     (gain),
    .chan_out (chan_out)
  );

  assign chan0_out = chan_out[0];
  assign chan1_out = chan_out[1];
  assign chan2_out = chan_out[2];

endmodule

// ===== test/radial_vignetting_gain_top_tb.sv =====
// ----------------------------------------------------------------------------
// radial_vignetting_gain_top_tb: self-checking bench for the radial gain block
// Programs the optical centre, normalising reciprocal and polynomial
// coefficients, streams pixels through the valid/stall channel and predicts
// every corrected pixel from a shadow copy of the registers. Each output beat
// is compared channel by channel against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module radial_vignetting_gain_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rvg_pkg::*;

  localparam int USED_CH          = 3;
  localparam int COORD_W          = 12;
  localparam int PIPE_LATENCY     = 12;
  localparam int SETTLE_CYCLES    = PIPE_LATENCY + 8;
  localparam int IDLE_PERCENT     = 7;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int BURST_PIXELS     = 48;
  localparam int RANDOM_PHASES    = 8;
  localparam int PIXELS_PER_PHASE = 160;
  localparam int QUIET_PHASE      = 2;
  localparam int CYCLE_LIMIT      = 200000;

  // Indexes past the end of the register map; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    pixel_row;
  logic [COORD_W-1:0]    pixel_col;
  pix_t                  chan0_in;
  pix_t                  chan1_in;
  pix_t                  chan2_in;
  logic                  out_valid;
  logic                  out_stall;
  pix_t                  chan0_out;
  pix_t                  chan1_out;
  pix_t                  chan2_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t        shadow_regs;         // register contents as the block should hold them
  chans_t      corrected_due[$];    // predicted pixels, oldest first
  int          mismatch_count = 0;
  bit          quiet          = 1'b0; // suppress random idling on both sides
  bit          hold_off_req   = 1'b0; // ask the receiver for one long stall
  int unsigned cycle_count;

  radial_vignetting_gain_top #(
    .CHANNELS   (USED_CH),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_row (pixel_row),
    .pixel_col (pixel_col),
    .chan0_in  (chan0_in),
    .chan1_in  (chan1_in),
    .chan2_in  (chan2_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .chan0_out (chan0_out),
    .chan1_out (chan1_out),
    .chan2_out (chan2_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Gain at (row, col) in signed Q4.12. Every intermediate is held at full
  // width, so only the documented rounding and saturation points apply.
  function automatic int lens_gain(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    longint          dy, dx, acc, g;
    longint unsigned dist_sq, r2, r4, r6;
    dy      = longint'(shadow_regs.centre_y) - longint'(row);
    dx      = longint'(shadow_regs.centre_x) - longint'(col);
    dist_sq = unsigned'(dy * dy + dx * dx);
    // Normalise to Q4.16, rounding half up; saturate rather than wrap
    r2 = (dist_sq * shadow_regs.recip + 64'h8000_0000) >> 32;
    if (r2 > R_MAX) r2 = R_MAX;
    r4 = (r2 * r2 + 64'h8000) >> 16;
    if (r4 > R_MAX) r4 = R_MAX;
    r6 = (r4 * r2 + 64'h8000) >> 16;
    if (r6 > R_MAX) r6 = R_MAX;
    acc = longint'($signed(shadow_regs.coef_r2)) * longint'(r2)
        + longint'($signed(shadow_regs.coef_r4)) * longint'(r4)
        + longint'($signed(shadow_regs.coef_r6)) * longint'(r6);
    // Q.28 back to Q4.12: round, then floor (arithmetic shift)
    g = ((acc + 32768) >>> 16) + 4096;
    if (g > 32767)  g = 32767;
    if (g < -32768) g = -32768;
    return int'(g);
  endfunction

  function automatic chans_t corrected_pixel(logic [COORD_W-1:0] row,
                                             logic [COORD_W-1:0] col, chans_t raw);
    chans_t fixed_px;
    int     gain;
    int     scaled;
    gain     = lens_gain(row, col);
    fixed_px = '0;
    for (int i = 0; i < FIELD_CH; i++) begin
      // A non-positive gain blanks the pixel outright
      if (i < USED_CH && gain > 0) begin
        scaled      = (int'(raw[i]) * gain + 2048) >> 12;
        fixed_px[i] = (scaled > 255) ? pix_t'(255) : pix_t'(scaled);
      end
    end
    return fixed_px;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One register write; the shadow copy follows only once the beat is taken
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTRE_X: shadow_regs.centre_x = data[CENTRE_W-1:0];
      REG_CENTRE_Y: shadow_regs.centre_y = data[CENTRE_W-1:0];
      REG_RECIP:    shadow_regs.recip    = data[RECIP_W-1:0];
      REG_COEF_R2:  shadow_regs.coef_r2  = data[COEF_W-1:0];
      REG_COEF_R4:  shadow_regs.coef_r4  = data[COEF_W-1:0];
      REG_COEF_R6:  shadow_regs.coef_r6  = data[COEF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one pixel and hold it until taken. Valid stays high on return so
  // back-to-back calls stream at full rate.
  task automatic send_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                            pix_t c0, pix_t c1, pix_t c2);
    chans_t raw;
    raw = {c2, c1, c0};
    @(negedge clk);
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    pixel_row <= row;
    pixel_col <= col;
    chan0_in  <= c0;
    chan1_in  <= c1;
    chan2_in  <= c2;
    do @(posedge clk); while (in_stall);
    corrected_due.push_back(corrected_pixel(row, col, raw));
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipe run dry
  task automatic wait_pipeline_empty();
    @(negedge clk);
    in_valid <= 1'b0;
    while (corrected_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_all_regs(logic [CENTRE_W-1:0] cx, logic [CENTRE_W-1:0] cy,
                                logic [RECIP_W-1:0] recip, logic [COEF_W-1:0] a,
                                logic [COEF_W-1:0] b, logic [COEF_W-1:0] c);
    write_reg(REG_CENTRE_X, CFG_DATA_W'(cx));
    write_reg(REG_CENTRE_Y, CFG_DATA_W'(cy));
    write_reg(REG_RECIP,    recip);
    write_reg(REG_COEF_R2,  CFG_DATA_W'(a));
    write_reg(REG_COEF_R4,  CFG_DATA_W'(b));
    write_reg(REG_COEF_R6,  CFG_DATA_W'(c));
  endtask

  // Random register set. Upper data bits carry junk that must be ignored.
  task automatic write_random_regs();
    logic [RECIP_W-1:0] recip;
    int unsigned        pick;
    int unsigned        dist_sq;
    write_reg(REG_CENTRE_X, $urandom);
    write_reg(REG_CENTRE_Y, $urandom);
    pick = $urandom_range(9);
    if (pick == 0) begin
      recip = '0;
    end else if (pick < 4) begin
      recip = $urandom;
    end else begin
      // Reciprocal of a plausible normalising distance squared
      dist_sq = $urandom_range(1 << 25, 65537);
      recip   = RECIP_W'((64'd1 << 48) / dist_sq);
    end
    write_reg(REG_RECIP, recip);
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(3);
      write_reg(REG_COEF_R2 + CFG_IDX_W'(k),
                (pick == 0) ? $urandom
                            : {16'($urandom), 16'($urandom_range(16383) - 8192)});
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : drive_out_stall
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall   <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every output beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_output
    chans_t want;
    chans_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {chan2_out, chan1_out, chan0_out};
      if (corrected_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: output beat with no pixel outstanding, expected none, actual %0d %0d %0d",
                 $time, got[0], got[1], got[2]);
      end else begin
        want = corrected_due.pop_front();
        for (int ch = 0; ch < FIELD_CH; ch++) begin
          if (got[ch] !== want[ch]) begin
            mismatch_count++;
            $display("%0t: chan%0d_out mismatch, expected %0d, actual %0d",
                     $time, ch, want[ch], got[ch]);
          end
        end
      end
    end
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("radial_vignetting_gain_top regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers come out of reset at zero: unit gain everywhere
  task automatic test_after_reset();
    send_pixel(12'd0,    12'd0,    8'd0,   8'd0,   8'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd0,    12'd4095, 8'd255, 8'd0,   8'd170);
    send_pixel(12'd4095, 12'd0,    8'd1,   8'd128, 8'd85);
    wait_pipeline_empty();
  endtask

  // Zero reciprocal forces r2 to zero, so strong coefficients have no effect
  task automatic test_zero_recip();
    write_all_regs(12'd2048, 12'd1024, 32'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_pixel(12'd0,    12'd0,    8'd200, 8'd17, 8'd255);
    send_pixel(12'd4095, 12'd4095, 8'd1,   8'd99, 8'd0);
    wait_pipeline_empty();
  endtask

  // Huge reciprocal: away from the centre r2, r4 and r6 pin at just below 16.0 instead of wrapping
  task automatic test_large_radius();
    write_all_regs(12'd0, 12'd0, 32'hFFFF_FFFF, 16'd1, 16'd1, 16'd1);
    send_pixel(12'd4095, 12'd4095, 8'd200, 8'd100, 8'd255);
    send_pixel(12'd4095, 12'd0,    8'd2,   8'd64,  8'd254);
    send_pixel(12'd1,    12'd1,    8'd255, 8'd128, 8'd7);
    wait_pipeline_empty();
  endtask

  // Gain of exactly zero and below blanks every channel
  task automatic test_nonpositive_gain();
    // r2 is exactly 1.0 at column 1024, and a = -1.0 cancels the unit term
    write_all_regs(12'd0, 12'd0, 32'h1000_0000, 16'hF000, 16'd0, 16'd0);
    send_pixel(12'd0, 12'd1024, 8'd255, 8'd128, 8'd1);
    send_pixel(12'd0, 12'd1023, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd0, 12'd0,    8'd90,  8'd45,  8'd255);
    wait_pipeline_empty();
    // Most negative coefficient drives the gain into saturation below zero
    write_reg(REG_COEF_R2, 32'h0000_8000);
    send_pixel(12'd0, 12'd2048, 8'd255, 8'd255, 8'd255);
    wait_pipeline_empty();
  endtask

  // Largest coefficients saturate the gain high; channels clamp at 255
  task automatic test_gain_ceiling();
    write_all_regs(12'd0, 12'd0, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pixel(12'd4095, 12'd4095, 8'd0, 8'd1,  8'd255);
    send_pixel(12'd2048, 12'd0,    8'd8, 8'd32, 8'd31);
    wait_pipeline_empty();
  endtask

  // Centre at the far corner, mixed extreme coefficients
  task automatic test_register_extremes();
    write_all_regs(12'd4095, 12'd4095, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0,   8'd128);
    send_pixel(12'd0,    12'd0,    8'd255, 8'd255, 8'd255);
    send_pixel(12'd4095, 12'd4094, 8'd255, 8'd64,  8'd3);
    wait_pipeline_empty();
  endtask

  // Writes beyond the register map leave the settings untouched
  task automatic test_spare_indexes();
    write_all_regs(12'd640, 12'd480, 32'h0004_0000, 16'h0800, 16'hFC00, 16'h0100);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    send_pixel(12'd0,   12'd0,   8'd100, 8'd150, 8'd200);
    send_pixel(12'd480, 12'd700, 8'd255, 8'd10,  8'd77);
    wait_pipeline_empty();
  endtask

  // Long output hold-off while pixels keep coming: the pipe must fill, stall
  // its input and then drain without losing or repeating a beat
  task automatic test_back_pressure();
    write_random_regs();
    hold_off_req = 1'b1;
    for (int n = 0; n < BURST_PIXELS; n++)
      send_pixel(COORD_W'($urandom), COORD_W'($urandom),
                 pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
    wait_pipeline_empty();
  endtask

  // Random registers per phase, random pixels, some clustered near the centre
  task automatic test_random_traffic();
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_random_regs();
      quiet = (phase == QUIET_PHASE);
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        if ($urandom_range(9) < 3) begin
          row = shadow_regs.centre_y + COORD_W'($urandom_range(128)) - COORD_W'(64);
          col = shadow_regs.centre_x + COORD_W'($urandom_range(128)) - COORD_W'(64);
        end else begin
          row = COORD_W'($urandom);
          col = COORD_W'($urandom);
        end
        send_pixel(row, col, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
      end
      wait_pipeline_empty();
      quiet = 1'b0;
    end
  endtask

  initial begin : run_tests
    rst         = 1'b1;
    in_valid    = 1'b0;
    pixel_row   = '0;
    pixel_col   = '0;
    chan0_in    = '0;
    chan1_in    = '0;
    chan2_in    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    shadow_regs = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_zero_recip();
    test_large_radius();
    test_nonpositive_gain();
    test_gain_ceiling();
    test_register_extremes();
    test_spare_indexes();
    test_back_pressure();
    test_random_traffic();

    wait_pipeline_empty();
    if (mismatch_count == 0)
      $display("radial_vignetting_gain_top regression: pass");
    else
      $display("radial_vignetting_gain_top regression: fail");
    $finish;
  end

endmodule
